// File: design/actr_pkg.sv
// Package: AES-128 tables, types and round functions for the CTR unit.
package actr_pkg;

    localparam int BLOCK_BYTES = 16;
    localparam int ROUNDS      = 10;

    typedef logic [127:0] t_block;
    typedef logic [4:0]   t_count;
    typedef logic [2:0]   t_cfg_idx;

    typedef enum logic [2:0] {
        REG_KEY_HIGH = 3'd0,
        REG_KEY_LOW  = 3'd1,
        REG_IV_HIGH  = 3'd2,
        REG_IV_LOW   = 3'd3
    } t_reg_idx;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON [ROUNDS] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of a block sits at bits [127-8i -: 8].
    function automatic t_block enc_round(input t_block st, input t_block rk, input logic last);
        logic [7:0] b [16];
        logic [7:0] s [16];
        logic [7:0] m [16];
        logic [7:0] t;
        t_block     o;
        for (int i = 0; i < 16; i++) begin
            b[i] = st[127 - 8 * i -: 8];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                s[r + 4 * c] = SBOX[b[r + 4 * ((c + r) % 4)]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            t = s[4*c] ^ s[4*c+1] ^ s[4*c+2] ^ s[4*c+3];
            m[4*c]   = s[4*c]   ^ t ^ xtime(s[4*c]   ^ s[4*c+1]);
            m[4*c+1] = s[4*c+1] ^ t ^ xtime(s[4*c+1] ^ s[4*c+2]);
            m[4*c+2] = s[4*c+2] ^ t ^ xtime(s[4*c+2] ^ s[4*c+3]);
            m[4*c+3] = s[4*c+3] ^ t ^ xtime(s[4*c+3] ^ s[4*c]);
        end
        for (int i = 0; i < 16; i++) begin
            o[127 - 8 * i -: 8] = (last ? s[i] : m[i]) ^ rk[127 - 8 * i -: 8];
        end
        return o;
    endfunction

    function automatic t_block next_round_key(input t_block k, input logic [7:0] rc);
        logic [31:0] w [4];
        logic [31:0] t;
        t_block      o;
        for (int j = 0; j < 4; j++) begin
            w[j] = k[127 - 32 * j -: 32];
        end
        t = {SBOX[w[3][23:16]] ^ rc, SBOX[w[3][15:8]], SBOX[w[3][7:0]], SBOX[w[3][31:24]]};
        w[0] = w[0] ^ t;
        w[1] = w[1] ^ w[0];
        w[2] = w[2] ^ w[1];
        w[3] = w[3] ^ w[2];
        o = {w[0], w[1], w[2], w[3]};
        return o;
    endfunction

endpackage

// File: design/actr_if.sv
// Interfaces: data-in, result-out and register-write channels.
interface actr_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic [4:0]  byte_count;
    logic        first_block;
    modport source (output valid, data_high, data_low, byte_count, first_block, input ready);
    modport sink   (input valid, data_high, data_low, byte_count, first_block, output ready);
endinterface

interface actr_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_high;
    logic [63:0] result_low;
    logic [4:0]  result_count;
    modport source (output valid, result_high, result_low, result_count, input ready);
    modport sink   (input valid, result_high, result_low, result_count, output ready);
endinterface

interface actr_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: design/aes128_ctr_decrypt_unit.sv
// Top level: AES-128 CTR keystream unit, one block per cycle while the result side is not stalled.
// Datapath: an input register, then a result register, between input transfer and result transfer.
// Throughput: one block per cycle without output stall; the ten AES rounds sit between the two registers.
// Round keys are registered in the key schedule, behind the key registers that a key register write updates.
// Synchronous active-low reset clears key, IV, counter and valid flags.
module aes128_ctr_decrypt_unit (
    input  logic     i_clk,
    input  logic     i_rst_n,
    actr_cfg_if.sink i_cfg,
    actr_in_if.sink  i_in,
    actr_out_if.source o_out
);
    logic [63:0]      r_key_high, r_key_low, r_iv_high, r_iv_low;
    actr_pkg::t_block r_ctr, n_ctr_use;
    logic             r_s1_v;
    actr_pkg::t_block r_s1_data, r_s1_ctr;
    actr_pkg::t_count r_s1_cnt, n_cnt;
    logic             r_out_v;
    actr_pkg::t_block r_out_data;
    actr_pkg::t_count r_out_cnt;
    actr_pkg::t_block rk [actr_pkg::ROUNDS + 1];
    actr_pkg::t_block ks, n_res;
    logic             out_adv, in_xfer;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
            r_iv_high  <= '0;
            r_iv_low   <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                actr_pkg::REG_KEY_HIGH: r_key_high <= i_cfg.data;
                actr_pkg::REG_KEY_LOW:  r_key_low  <= i_cfg.data;
                actr_pkg::REG_IV_HIGH:  r_iv_high  <= i_cfg.data;
                actr_pkg::REG_IV_LOW:   r_iv_low   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    actr_key_sched u_key_sched (
        .i_clk (i_clk),
        .i_key ({r_key_high, r_key_low}),
        .o_rk  (rk)
    );

    assign out_adv     = !r_out_v || o_out.ready;
    assign i_in.ready  = !r_s1_v || out_adv;
    assign in_xfer     = i_in.valid && i_in.ready;

    assign n_ctr_use = i_in.first_block ? {r_iv_high, r_iv_low} : r_ctr;
    assign n_cnt     = (i_in.byte_count > 5'(actr_pkg::BLOCK_BYTES))
                       ? 5'(actr_pkg::BLOCK_BYTES) : i_in.byte_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr  <= '0;
            r_s1_v <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_ctr <= n_ctr_use + 128'd1;
            end
            if (i_in.ready) begin
                r_s1_v <= i_in.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_data <= {i_in.data_high, i_in.data_low};
            r_s1_ctr  <= n_ctr_use;
            r_s1_cnt  <= n_cnt;
        end
    end

    actr_cipher u_cipher (
        .i_ctr (r_s1_ctr),
        .i_rk  (rk),
        .o_ks  (ks)
    );

    always_comb begin
        for (int k = 0; k < actr_pkg::BLOCK_BYTES; k++) begin
            n_res[127 - 8 * k -: 8] = (5'(k) < r_s1_cnt)
                ? (r_s1_data[127 - 8 * k -: 8] ^ ks[127 - 8 * k -: 8]) : 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_adv) begin
            r_out_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_s1_v) begin
            r_out_data <= n_res;
            r_out_cnt  <= r_s1_cnt;
        end
    end

    assign o_out.valid        = r_out_v;
    assign o_out.result_high  = r_out_data[127:64];
    assign o_out.result_low   = r_out_data[63:0];
    assign o_out.result_count = r_out_cnt;
endmodule

// File: design/actr_key_sched.sv
// Key schedule: registered round keys derived from the key registers.
module actr_key_sched (
    input  logic            i_clk,
    input  actr_pkg::t_block i_key,
    output actr_pkg::t_block o_rk [actr_pkg::ROUNDS + 1]
);
    actr_pkg::t_block n_rk [actr_pkg::ROUNDS + 1];
    actr_pkg::t_block r_rk [actr_pkg::ROUNDS + 1];

    always_comb begin
        n_rk[0] = i_key;
        for (int i = 1; i <= actr_pkg::ROUNDS; i++) begin
            n_rk[i] = actr_pkg::next_round_key(n_rk[i-1], actr_pkg::RCON[i-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rk <= n_rk;
    end

    assign o_rk = r_rk;
endmodule

// File: design/actr_cipher.sv
// AES-128 encryption of the counter block with precomputed round keys.
module actr_cipher (
    input  actr_pkg::t_block i_ctr,
    input  actr_pkg::t_block i_rk [actr_pkg::ROUNDS + 1],
    output actr_pkg::t_block o_ks
);
    actr_pkg::t_block st [actr_pkg::ROUNDS + 1];

    always_comb begin
        st[0] = i_ctr ^ i_rk[0];
        for (int r = 1; r <= actr_pkg::ROUNDS; r++) begin
            st[r] = actr_pkg::enc_round(st[r-1], i_rk[r], r == actr_pkg::ROUNDS);
        end
    end

    assign o_ks = st[actr_pkg::ROUNDS];
endmodule

// File: design/actr_checker.sv
// Checker: port-level properties of the CTR unit, bound to the top level.
module actr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_result_high,
    input logic [63:0] i_result_low,
    input logic [4:0]  i_result_count
);
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_result_count <= 5'd16)
        else $error("result count above block size");

    a_zero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_result_count == 5'd0 |-> i_result_high == '0 && i_result_low == '0)
        else $error("nonzero bytes with zero count");

    a_tail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_result_count < 5'd16 |-> i_result_low[7:0] == 8'h00)
        else $error("last byte set past the valid count");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_result_high)
            && $stable(i_result_low) && $stable(i_result_count))
        else $error("stalled result changed");
endmodule

bind aes128_ctr_decrypt_unit actr_checker u_actr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_result_high  (o_out.result_high),
    .i_result_low   (o_out.result_low),
    .i_result_count (o_out.result_count)
);

// File: tb/tb_top.sv
// Testbench: AES-128 CTR unit checked against an in-bench AES predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [63:0] data_high;
        logic [63:0] data_low;
        logic [4:0]  byte_count;
        logic        first_block;
    } t_blk_in;

    typedef struct {
        logic [63:0] result_high;
        logic [63:0] result_low;
        logic [4:0]  result_count;
    } t_blk_out;

    typedef struct {
        actr_pkg::t_reg_idx idx;
        logic [63:0]        data;
    } t_reg_wr;

    logic i_clk;
    logic i_rst_n;

    actr_cfg_if cfg_ch ();
    actr_in_if  in_ch ();
    actr_out_if out_ch ();

    aes128_ctr_decrypt_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch.sink),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    t_blk_in  pending_blocks[$];
    t_blk_out expected_blocks[$];
    t_reg_wr  pending_writes[$];

    logic [127:0] key_reg, iv_reg, ctr_reg;
    int           mismatches;
    int           burst_left;
    int           gap_left;
    int           stall_phase;
    int           stall_len;
    logic         stim_done;

    logic [7:0] sb [256];
    initial begin
        sb = '{
            8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
            8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
            8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
            8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
            8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
            8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
            8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
            8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
            8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
            8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
            8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
            8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
            8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
            8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
            8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
            8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
    end

    function automatic logic [7:0] gf2(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of a 128-bit value at bits [127-8i -: 8]
    function automatic logic [127:0] aes_encrypt(input logic [127:0] key, input logic [127:0] pt);
        logic [7:0] rk [176];
        logic [7:0] st [16];
        logic [7:0] tp [16];
        logic [7:0] w [4];
        logic [7:0] a0, a1, a2, a3, t, s0;
        logic [7:0] rc;
        logic [127:0] o;
        rc = 8'h01;
        for (int i = 0; i < 16; i++) rk[i] = key[127 - 8 * i -: 8];
        for (int i = 4; i < 44; i++) begin
            for (int j = 0; j < 4; j++) w[j] = rk[4 * (i - 1) + j];
            if (i % 4 == 0) begin
                s0 = w[0];
                w[0] = sb[w[1]] ^ rc;
                w[1] = sb[w[2]];
                w[2] = sb[w[3]];
                w[3] = sb[s0];
                rc = gf2(rc);
            end
            for (int j = 0; j < 4; j++) rk[4 * i + j] = rk[4 * (i - 4) + j] ^ w[j];
        end
        for (int i = 0; i < 16; i++) st[i] = pt[127 - 8 * i -: 8] ^ rk[i];
        for (int rnd = 1; rnd <= 10; rnd++) begin
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    tp[r + 4 * c] = sb[st[r + 4 * ((c + r) % 4)]];
            if (rnd < 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = tp[4*c]; a1 = tp[4*c+1]; a2 = tp[4*c+2]; a3 = tp[4*c+3];
                    t = a0 ^ a1 ^ a2 ^ a3;
                    tp[4*c]   = a0 ^ t ^ gf2(a0 ^ a1);
                    tp[4*c+1] = a1 ^ t ^ gf2(a1 ^ a2);
                    tp[4*c+2] = a2 ^ t ^ gf2(a2 ^ a3);
                    tp[4*c+3] = a3 ^ t ^ gf2(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++) st[i] = tp[i] ^ rk[16 * rnd + i];
        end
        for (int i = 0; i < 16; i++) o[127 - 8 * i -: 8] = st[i];
        return o;
    endfunction

    function automatic t_blk_out ctr_decrypt_block(input t_blk_in b);
        t_blk_out     r;
        logic [127:0] ks, d;
        int           n;
        n = (b.byte_count > 16) ? 16 : b.byte_count;
        if (b.first_block) ctr_reg = iv_reg;
        ks = aes_encrypt(key_reg, ctr_reg);
        d = {b.data_high, b.data_low} ^ ks;
        for (int k = 0; k < 16; k++)
            if (k >= n) d[127 - 8 * k -: 8] = 8'h00;
        ctr_reg = ctr_reg + 128'd1;
        r.result_high = d[127:64];
        r.result_low = d[63:0];
        r.result_count = 5'(n);
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_ch.valid) expected_blocks.push_back(ctr_decrypt_block(pending_blocks.pop_front()));
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_ch.valid <= 1'b0;
            end else if (pending_blocks.size() > 0) begin
                in_ch.valid <= 1'b1;
                in_ch.data_high <= pending_blocks[0].data_high;
                in_ch.data_low <= pending_blocks[0].data_low;
                in_ch.byte_count <= pending_blocks[0].byte_count;
                in_ch.first_block <= pending_blocks[0].first_block;
                if (burst_left > 0) burst_left <= burst_left - 1;
                else begin
                    burst_left <= $urandom_range(0, 30);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // register write driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_ch.valid <= 1'b0;
        end else if (!cfg_ch.valid || cfg_ch.ready) begin
            if (cfg_ch.valid) begin
                case (pending_writes[0].idx)
                    actr_pkg::REG_KEY_HIGH: key_reg[127:64] = pending_writes[0].data;
                    actr_pkg::REG_KEY_LOW:  key_reg[63:0] = pending_writes[0].data;
                    actr_pkg::REG_IV_HIGH:  iv_reg[127:64] = pending_writes[0].data;
                    actr_pkg::REG_IV_LOW:   iv_reg[63:0] = pending_writes[0].data;
                    default: ;
                endcase
                void'(pending_writes.pop_front());
            end
            if (pending_writes.size() > 0) begin
                cfg_ch.valid <= 1'b1;
                cfg_ch.index <= actr_pkg::t_cfg_idx'(pending_writes[0].idx);
                cfg_ch.data <= pending_writes[0].data;
            end else begin
                cfg_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor and sink stall pattern
    always @(posedge i_clk) begin
        t_blk_out e;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_phase <= 0;
            stall_len <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_blocks.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10) $display("unexpected result transfer %h %h %0d",
                        out_ch.result_high, out_ch.result_low, out_ch.result_count);
                end else begin
                    e = expected_blocks.pop_front();
                    if (e.result_high !== out_ch.result_high || e.result_low !== out_ch.result_low
                            || e.result_count !== out_ch.result_count) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("mismatch exp %h %h %0d got %h %h %0d",
                                e.result_high, e.result_low, e.result_count,
                                out_ch.result_high, out_ch.result_low, out_ch.result_count);
                    end
                end
            end
            // alternate stretches: always ready, periodic stall, random stall
            if (stall_len == 0) begin
                stall_phase <= $urandom_range(0, 2);
                stall_len <= $urandom_range(10, 60);
                out_ch.ready <= 1'b1;
            end else begin
                stall_len <= stall_len - 1;
                case (stall_phase)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= (stall_len % 4) != 0;
                    default: out_ch.ready <= $urandom_range(0, 2) != 0;
                endcase
            end
        end
    end

    task automatic queue_block(input logic [63:0] dh, input logic [63:0] dl,
                               input logic [4:0] cnt, input logic fb);
        t_blk_in b;
        b.data_high = dh;
        b.data_low = dl;
        b.byte_count = cnt;
        b.first_block = fb;
        pending_blocks.push_back(b);
    endtask

    task automatic write_reg(input actr_pkg::t_reg_idx idx, input logic [63:0] v);
        t_reg_wr w;
        w.idx = idx;
        w.data = v;
        pending_writes.push_back(w);
    endtask

    task automatic drain_and_settle();
        wait (pending_blocks.size() == 0 && !in_ch.valid && expected_blocks.size() == 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_key_iv(input logic [127:0] k, input logic [127:0] v);
        write_reg(actr_pkg::REG_KEY_HIGH, k[127:64]);
        write_reg(actr_pkg::REG_KEY_LOW, k[63:0]);
        write_reg(actr_pkg::REG_IV_HIGH, v[127:64]);
        write_reg(actr_pkg::REG_IV_LOW, v[63:0]);
        wait (pending_writes.size() == 0 && !cfg_ch.valid);
        repeat (3) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    initial begin
        logic [127:0] k, v;
        int           seg;
        mismatches = 0;
        stim_done = 1'b0;
        key_reg = '0;
        iv_reg = '0;
        ctr_reg = '0;
        in_ch.valid = 1'b0;
        in_ch.data_high = '0;
        in_ch.data_low = '0;
        in_ch.byte_count = '0;
        in_ch.first_block = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        out_ch.ready = 1'b0;
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset key/IV/counter, no first-block flag
        queue_block('0, '0, 5'd16, 1'b0);
        queue_block('1, '1, 5'd16, 1'b0);
        drain_and_settle();

        // FIPS-197 key, counter wrap from all ones
        set_key_iv(128'h000102030405060708090a0b0c0d0e0f, '1);
        queue_block('0, '0, 5'd16, 1'b1);
        queue_block('1, '1, 5'd16, 1'b0);
        queue_block(rand64(), rand64(), 5'd0, 1'b0);
        queue_block(rand64(), rand64(), 5'd1, 1'b0);
        queue_block(rand64(), rand64(), 5'd8, 1'b0);
        queue_block(rand64(), rand64(), 5'd9, 1'b0);
        queue_block(rand64(), rand64(), 5'd15, 1'b0);
        queue_block(rand64(), rand64(), 5'd17, 1'b0);
        queue_block(rand64(), rand64(), 5'd31, 1'b1);
        drain_and_settle();

        // all-ones key, low half wrap into high half
        set_key_iv('1, {64'h0123456789abcdef, 64'hffffffffffffffff});
        queue_block('1, '0, 5'd16, 1'b1);
        queue_block('0, '1, 5'd16, 1'b0);
        queue_block(rand64(), rand64(), 5'd16, 1'b0);
        queue_block(rand64(), rand64(), 5'd16, 1'b1);
        drain_and_settle();

        for (seg = 0; seg < 8; seg++) begin
            k = {rand64(), rand64()};
            v = {rand64(), rand64()};
            if (seg == 1) v[63:0] = 64'hffffffffffffff00;
            if (seg == 2) v = {64'hffffffffffffffff, 64'hfffffffffffffff0};
            set_key_iv(k, v);
            queue_block(rand64(), rand64(), 5'd16, 1'b1);
            for (int i = 0; i < 180; i++) begin
                logic [4:0] c;
                case ($urandom_range(0, 9))
                    0: c = 5'($urandom_range(0, 31));
                    1: c = 5'($urandom_range(1, 15));
                    default: c = 5'd16;
                endcase
                queue_block(rand64(), rand64(), c, $urandom_range(0, 40) == 0);
            end
            drain_and_settle();
        end
        stim_done = 1'b1;
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && expected_blocks.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("status: fail");
        $finish;
    end
endmodule
